// ===== hw/rtl/life_cellular_automaton_grid_defines.svh =====
// Assertion macros used by the grid top-level RTL file.
`ifndef LIFE_CELLULAR_AUTOMATON_GRID_DEFINES_SVH
`define LIFE_CELLULAR_AUTOMATON_GRID_DEFINES_SVH
`ifndef SYNTHESIS
`define LCAG_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid assertion failed");
`define LCAG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid assertion failed");
`else
`define LCAG_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define LCAG_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/lcag_pkg.sv =====
// Shared types and constants of the cellular automaton grid.
`timescale 1ns / 1ps
package lcag_pkg;

    localparam int FUNC_W = 2;
    localparam int POS_W  = 11;

    // Pixel-to-cell division uses a reciprocal with this many fraction bits.
    // It is exact for an 11-bit dividend and any cell size up to 64.
    localparam int DIV_SHIFT = POS_W + 6;
    localparam int PROD_W    = POS_W + DIV_SHIFT + 1;

    localparam int QUEUE_DEPTH = 2;

    localparam int GRID_ROWS_DEF   = 32;
    localparam int GRID_COLS_DEF   = 32;
    localparam int CELL_PIXELS_DEF = 40;

    typedef enum logic [FUNC_W-1:0] {
        OP_SET   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_STEP  = 2'd3
    } op_t;

    typedef enum logic {
        ENG_IDLE,
        ENG_STEP
    } eng_state_t;

    typedef struct packed {
        op_t              op;
        logic             alive;
        logic             on_grid;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic step_last;
    } eng_status_t;

endpackage

// ===== hw/rtl/lcag_req_if.sv =====
// Request channel interface of the cellular automaton grid.
`timescale 1ns / 1ps
interface lcag_req_if;
    logic                        valid;
    logic                        ready;
    logic [lcag_pkg::FUNC_W-1:0] func;
    logic                        alive_value;
    logic [lcag_pkg::POS_W-1:0]  pos_x;
    logic [lcag_pkg::POS_W-1:0]  pos_y;

    modport source (output valid, func, alive_value, pos_x, pos_y, input ready);
    modport sink (input valid, func, alive_value, pos_x, pos_y, output ready);
endinterface

// ===== hw/rtl/lcag_rsp_if.sv =====
// Result channel interface of the cellular automaton grid.
`timescale 1ns / 1ps
interface lcag_rsp_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic out_of_range;

    modport source (output valid, cell_alive, out_of_range, input ready);
    modport sink (input valid, cell_alive, out_of_range, output ready);
endinterface

// ===== hw/rtl/lcag_front.sv =====
// Front end: accepts requests, maps pixel positions to cells and classifies them.
`timescale 1ns / 1ps
module lcag_front #(
    parameter int GRID_ROWS   = lcag_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS   = lcag_pkg::GRID_COLS_DEF,
    parameter int CELL_PIXELS = lcag_pkg::CELL_PIXELS_DEF
) (
    lcag_req_if.sink       req,
    input  logic           q_full,
    output logic           push,
    output lcag_pkg::cmd_t cmd
);

    localparam int RECIP = ((1 << lcag_pkg::DIV_SHIFT) + CELL_PIXELS - 1) / CELL_PIXELS;

    logic [lcag_pkg::PROD_W-1:0] prod_x;
    logic [lcag_pkg::PROD_W-1:0] prod_y;
    logic [lcag_pkg::POS_W-1:0]  col;
    logic [lcag_pkg::POS_W-1:0]  row;

    // Division by the cell size as a multiply by its rounded-up reciprocal.
    assign prod_x = lcag_pkg::PROD_W'(req.pos_x) * lcag_pkg::PROD_W'(RECIP);
    assign prod_y = lcag_pkg::PROD_W'(req.pos_y) * lcag_pkg::PROD_W'(RECIP);
    assign col    = prod_x[lcag_pkg::DIV_SHIFT +: lcag_pkg::POS_W];
    assign row    = prod_y[lcag_pkg::DIV_SHIFT +: lcag_pkg::POS_W];

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    always_comb
    begin
        cmd.op      = lcag_pkg::op_t'(req.func);
        cmd.alive   = req.alive_value;
        cmd.on_grid = (row < lcag_pkg::POS_W'(GRID_ROWS))
                   && (col < lcag_pkg::POS_W'(GRID_COLS));
        cmd.row     = row;
        cmd.col     = col;
    end

endmodule

// ===== hw/rtl/lcag_queue.sv =====
// Short command queue between the front end and the grid engine.
`timescale 1ns / 1ps
module lcag_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lcag_pkg::cmd_t cmd_in,
    output logic           full,
    output logic           not_empty,
    input  logic           pop,
    output lcag_pkg::cmd_t cmd_out
);

    localparam int DEPTH = lcag_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcag_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign cmd_out   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== hw/rtl/lcag_engine.sv =====
// Grid engine: holds the cells and carries out set, query, clear and step.
`timescale 1ns / 1ps
module lcag_engine #(
    parameter int GRID_ROWS = lcag_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lcag_pkg::GRID_COLS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  lcag_pkg::cmd_t        q_cmd,
    output logic                  q_pop,
    lcag_rsp_if.source            rsp,
    output lcag_pkg::eng_status_t status
);

    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int COL_W = $clog2(GRID_COLS);

    lcag_pkg::eng_state_t state_reg, state_next;
    logic [GRID_COLS-1:0] grid_reg [GRID_ROWS];
    logic [GRID_COLS-1:0] grid_next [GRID_ROWS];
    logic [GRID_COLS-1:0] prev_reg, prev_next;
    logic [ROW_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_alive_reg, out_alive_next;
    logic                 out_oor_reg, out_oor_next;

    logic                 out_free;
    logic                 step_last;
    logic [ROW_W-1:0]     row_idx;
    logic [COL_W-1:0]     col_idx;
    logic [GRID_COLS-1:0] below_row;
    logic [GRID_COLS+1:0] pad_a, pad_m, pad_b;
    logic [3:0]           nbr_cnt [GRID_COLS];
    logic [GRID_COLS-1:0] new_row;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign step_last = (state_reg == lcag_pkg::ENG_STEP) && (cnt_reg == ROW_W'(GRID_ROWS - 1));
    assign q_pop     = (state_reg == lcag_pkg::ENG_IDLE) && q_valid && out_free;
    assign row_idx   = q_cmd.row[ROW_W-1:0];
    assign col_idx   = q_cmd.col[COL_W-1:0];

    // The sweep works on the head row; the row above was saved on the way
    // out and the row below is the next one in line, dead past the last row.
    assign below_row = step_last ? '0 : grid_reg[1];
    assign pad_a     = {1'b0, prev_reg, 1'b0};
    assign pad_m     = {1'b0, grid_reg[0], 1'b0};
    assign pad_b     = {1'b0, below_row, 1'b0};

    always_comb
    begin
        for (int c = 0; c < GRID_COLS; c++)
        begin
            nbr_cnt[c] = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
                       + 4'(pad_m[c]) + 4'(pad_m[c+2])
                       + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);
            new_row[c] = (nbr_cnt[c] == 4'd3) || (pad_m[c+1] && (nbr_cnt[c] == 4'd2));
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcag_pkg::ENG_IDLE:
            begin
                if (q_pop && (q_cmd.op == lcag_pkg::OP_STEP))
                begin
                    state_next = lcag_pkg::ENG_STEP;
                end
            end
            lcag_pkg::ENG_STEP:
            begin
                if (step_last)
                begin
                    state_next = lcag_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = lcag_pkg::ENG_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        grid_next      = grid_reg;
        prev_next      = prev_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_alive_next = out_alive_reg;
        out_oor_next   = out_oor_reg;
        case (state_reg)
            lcag_pkg::ENG_IDLE:
            begin
                if (q_pop)
                begin
                    out_alive_next = 1'b0;
                    out_oor_next   = 1'b0;
                    case (q_cmd.op)
                        lcag_pkg::OP_SET:
                        begin
                            out_valid_next = 1'b1;
                            out_oor_next   = !q_cmd.on_grid;
                            if (q_cmd.on_grid)
                            begin
                                grid_next[row_idx][col_idx] = q_cmd.alive;
                            end
                        end
                        lcag_pkg::OP_QUERY:
                        begin
                            out_valid_next = 1'b1;
                            out_oor_next   = !q_cmd.on_grid;
                            out_alive_next = q_cmd.on_grid ? grid_reg[row_idx][col_idx]
                                                           : 1'b0;
                        end
                        lcag_pkg::OP_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            for (int r = 0; r < GRID_ROWS; r++)
                            begin
                                grid_next[r] = '0;
                            end
                        end
                        default:
                        begin
                            prev_next = '0;
                            cnt_next  = '0;
                        end
                    endcase
                end
            end
            lcag_pkg::ENG_STEP:
            begin
                for (int r = 0; r < GRID_ROWS - 1; r++)
                begin
                    grid_next[r] = grid_reg[r+1];
                end
                grid_next[GRID_ROWS-1] = new_row;
                prev_next = grid_reg[0];
                cnt_next  = cnt_reg + 1'b1;
                if (step_last)
                begin
                    out_valid_next = 1'b1;
                    out_alive_next = 1'b0;
                    out_oor_next   = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcag_pkg::ENG_IDLE;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                grid_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            grid_reg      <= grid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        cnt_reg       <= cnt_next;
        out_alive_reg <= out_alive_next;
        out_oor_reg   <= out_oor_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.cell_alive   = out_alive_reg;
    assign rsp.out_of_range = out_oor_reg;

    assign status.busy      = (state_reg == lcag_pkg::ENG_STEP);
    assign status.step_last = step_last;

endmodule

// ===== hw/rtl/life_cellular_automaton_grid.sv =====
// Top level of the B3/S23 cellular automaton grid.
`timescale 1ns / 1ps
`include "life_cellular_automaton_grid_defines.svh"
// This block keeps a GRID_ROWS by GRID_COLS grid of cells in flip-flops,
// cleared to all dead at reset, and answers every request with exactly one
// result. A request sets one cell, queries one cell, clears the grid, or
// advances the grid one generation under the B3/S23 rule, with cells past the
// border counted as dead. Set and query address a cell by pixel position: the
// row is pos_y divided by CELL_PIXELS and the column pos_x divided by
// CELL_PIXELS, and a position off the grid leaves the grid alone and returns
// out_of_range. The front end converts the position with a reciprocal
// multiply and writes a decoded command into a two-entry queue; the engine
// behind it takes one command at a time. Set, query and clear flow at one
// request per cycle while the result side is not stalled; a request passes
// through the queue and then the result register before its result appears.
// A step holds the engine while it sweeps the rows once, shifting the row
// registers by one position per cycle and computing the new row from a
// three-row window as it goes; the next command starts only after the sweep.
// A stalled result register holds its result while the queue keeps taking
// requests until it is full.
module life_cellular_automaton_grid #(
    parameter int GRID_ROWS   = lcag_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS   = lcag_pkg::GRID_COLS_DEF,
    parameter int CELL_PIXELS = lcag_pkg::CELL_PIXELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lcag_req_if.sink   req,
    lcag_rsp_if.source rsp
);

    logic                  q_full;
    logic                  q_push;
    logic                  q_valid;
    logic                  q_pop;
    lcag_pkg::cmd_t        front_cmd;
    lcag_pkg::cmd_t        q_cmd;
    lcag_pkg::eng_status_t status;

    // Front end: position to cell conversion and request decode.
    lcag_front #(
        .GRID_ROWS   (GRID_ROWS),
        .GRID_COLS   (GRID_COLS),
        .CELL_PIXELS (CELL_PIXELS)
    ) u_front (
        .req    (req),
        .q_full (q_full),
        .push   (q_push),
        .cmd    (front_cmd)
    );

    // Decoupling queue so the front end keeps accepting during a step.
    lcag_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .cmd_in    (front_cmd),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (q_pop),
        .cmd_out   (q_cmd)
    );

    // Engine: owns the grid and the result register.
    lcag_engine #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .rsp     (rsp),
        .status  (status)
    );

    // The engine must not take a new command while a generation sweep runs.
    `LCAG_ASSERT_IMPL(a_no_pop_in_step, clk, rst_n, status.busy, !q_pop)
    // A sweep that has not reached its last row is still running next cycle.
    `LCAG_ASSERT_NEXT(a_step_continues, clk, rst_n, status.busy && !status.step_last, status.busy)
    // The last row of a sweep always produces the step's result.
    `LCAG_ASSERT_NEXT(a_step_result, clk, rst_n, status.step_last, rsp.valid)
    // A cell can only read as alive when its position was on the grid.
    `LCAG_ASSERT_IMPL(a_result_exclusive, clk, rst_n, rsp.valid, !(rsp.cell_alive && rsp.out_of_range))

endmodule

// ===== tb/life_cellular_automaton_grid_tb.sv =====
// Self-checking testbench for the B3/S23 cellular automaton grid.
`timescale 1ns / 1ps
module life_cellular_automaton_grid_tb;

    import lcag_pkg::*;

    // Grid geometry used for this run; the block is built with the same values.
    localparam int ROWS = GRID_ROWS_DEF;
    localparam int COLS = GRID_COLS_DEF;
    localparam int CELL = CELL_PIXELS_DEF;
    localparam int POS_MAX = (1 << POS_W) - 1;

    // Random request budget; each of the four handshake phases queues at least RAND_REQS / 4.
    localparam int RAND_REQS = 1925;
    // The receiver holds off this long once, so that the request queue fills.
    localparam int LONG_HOLD = 300;
    // Cycles with no handshake on either side before the run is abandoned.
    // The longest legal gap comes from a step or from the long hold, and this
    // limit is many times that gap.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles allowed after the last result for a stray result to show up.
    localparam int DRAIN_CYCLES = 4 * ROWS;

    typedef struct packed {
        op_t              op;
        logic             alive;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
    } grid_req_t;

    typedef struct packed {
        logic cell_alive;
        logic out_of_range;
    } grid_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    lcag_req_if req_bus ();
    lcag_rsp_if rsp_bus ();

    life_cellular_automaton_grid #(
        .GRID_ROWS   (ROWS),
        .GRID_COLS   (COLS),
        .CELL_PIXELS (CELL)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #5 clk = ~clk;

    // Requests waiting to be offered, and results still owed by the block.
    grid_req_t pending_reqs[$];
    grid_rsp_t owed_rsps[$];
    grid_req_t offered_req;

    // Our own copy of the live cells, one row word per grid row.
    logic [COLS-1:0] life_grid [ROWS];

    // Handshake pressure, set per phase by the stimulus process.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;

    int unsigned errors       = 0;
    int unsigned queued_count = 0;
    int unsigned rsp_checked  = 0;
    int unsigned n_set        = 0;
    int unsigned n_query      = 0;
    int unsigned n_clear      = 0;
    int unsigned n_step       = 0;
    int unsigned n_off_grid   = 0;
    int unsigned n_live_seen  = 0;
    int unsigned idle_cycles  = 0;

    // A cell outside the grid always counts as dead.
    function automatic logic cell_at(int r, int c);
        if (r < 0 || r >= ROWS || c < 0 || c >= COLS)
            return 1'b0;
        return life_grid[r][c];
    endfunction

    // One generation of B3/S23 over the whole grid, built from the old grid
    // before any row is replaced.
    function automatic void advance_generation();
        logic [COLS-1:0] nxt [ROWS];
        int n;
        for (int r = 0; r < ROWS; r++)
        begin
            nxt[r] = '0;
            for (int c = 0; c < COLS; c++)
            begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            n += cell_at(r + dr, c + dc);
                nxt[r][c] = life_grid[r][c] ? (n == 2 || n == 3) : (n == 3);
            end
        end
        life_grid = nxt;
    endfunction

    // Applies one accepted request to the grid copy and returns the result
    // the block owes for it.
    function automatic grid_rsp_t grid_apply(grid_req_t rq);
        grid_rsp_t   rs;
        int unsigned row;
        int unsigned col;
        logic        on_grid;
        rs      = '0;
        row     = rq.py / CELL;
        col     = rq.px / CELL;
        on_grid = (row < ROWS) && (col < COLS);
        case (rq.op)
            OP_SET:
            begin
                n_set++;
                if (on_grid)
                    life_grid[row][col] = rq.alive;
                else
                    rs.out_of_range = 1'b1;
            end
            OP_QUERY:
            begin
                n_query++;
                if (on_grid)
                    rs.cell_alive = life_grid[row][col];
                else
                    rs.out_of_range = 1'b1;
                n_live_seen += rs.cell_alive;
            end
            OP_CLEAR:
            begin
                n_clear++;
                foreach (life_grid[r])
                    life_grid[r] = '0;
            end
            default:
            begin
                n_step++;
                advance_generation();
            end
        endcase
        n_off_grid += rs.out_of_range;
        return rs;
    endfunction

    function automatic void add_req(op_t op, logic alive, int px, int py);
        grid_req_t rq;
        rq.op    = op;
        rq.alive = alive;
        rq.px    = px[POS_W-1:0];
        rq.py    = py[POS_W-1:0];
        pending_reqs.push_back(rq);
        queued_count++;
    endfunction

    // A random pixel position that falls inside the given cell index.
    function automatic int cell_px(int idx);
        return idx * CELL + $urandom_range(CELL - 1);
    endfunction

    // Left or top corner of a 6 by 6 window, pushed against a border about
    // two times in three so that edge neighbors get exercised.
    function automatic int window_base(int span);
        case ($urandom_range(2))
            0:       return 0;
            1:       return span - 6;
            default: return $urandom_range(span - 6);
        endcase
    endfunction

    // Driver. A request stays on the bus until the block takes it; on
    // acceptance its result is predicted and queued, and the next request is
    // offered at once unless the sender decides to idle this cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid       <= 1'b0;
            req_bus.func        <= OP_SET;
            req_bus.alive_value <= 1'b0;
            req_bus.pos_x       <= '0;
            req_bus.pos_y       <= '0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                owed_rsps.push_back(grid_apply(offered_req));
            if (!req_bus.valid || req_bus.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_req          = pending_reqs.pop_front();
                    req_bus.valid       <= 1'b1;
                    req_bus.func        <= offered_req.op;
                    req_bus.alive_value <= offered_req.alive;
                    req_bus.pos_x       <= offered_req.px;
                    req_bus.pos_y       <= offered_req.py;
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each result taken from the block is compared with the oldest
    // owed result. The ready it drives for the next cycle either follows the
    // phase's stall rate or, once per run, stays low for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (owed_rsps.size() == 0)
                begin
                    $error("result with no request outstanding: cell_alive %0b out_of_range %0b",
                           rsp_bus.cell_alive, rsp_bus.out_of_range);
                    errors++;
                end
                else
                begin
                    grid_rsp_t want;
                    want = owed_rsps.pop_front();
                    rsp_checked++;
                    if (rsp_bus.cell_alive !== want.cell_alive)
                    begin
                        $error("cell_alive: expected %0b, actual %0b",
                               want.cell_alive, rsp_bus.cell_alive);
                        errors++;
                    end
                    if (rsp_bus.out_of_range !== want.out_of_range)
                    begin
                        $error("out_of_range: expected %0b, actual %0b",
                               want.out_of_range, rsp_bus.out_of_range);
                        errors++;
                    end
                end
            end
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: gives up when neither side has completed a handshake
    // within the WATCHDOG_LIMIT window.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results still owed",
                         WATCHDOG_LIMIT, owed_rsps.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int phase;
        int target;
        int base_r;
        int base_c;
        int kind;

        rst_n = 1'b0;
        foreach (life_grid[r])
            life_grid[r] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests. A horizontal blinker on the top border must fold
        // into a vertical pair, since cells above row 0 count as dead. An L of
        // three cells in the bottom right corner must grow into a block.
        add_req(OP_QUERY, 1'b1, 0, 0);
        add_req(OP_SET, 1'b1, 0, 0);
        add_req(OP_SET, 1'b1, CELL + CELL - 1, CELL - 1);
        add_req(OP_SET, 1'b1, 2 * CELL, 1);
        add_req(OP_SET, 1'b1, COLS * CELL - 1, ROWS * CELL - 1);
        add_req(OP_SET, 1'b1, (COLS - 2) * CELL, (ROWS - 1) * CELL);
        add_req(OP_SET, 1'b1, (COLS - 1) * CELL, (ROWS - 2) * CELL);
        // Off-grid positions: just past the last column, the largest row, both
        // coordinates at the top of their range, and just past the last row. None
        // of them may touch the grid.
        add_req(OP_SET, 1'b1, COLS * CELL, 0);
        add_req(OP_SET, 1'b0, 0, POS_MAX);
        add_req(OP_QUERY, 1'b0, POS_MAX, POS_MAX);
        add_req(OP_QUERY, 1'b1, 0, ROWS * CELL);
        add_req(OP_QUERY, 1'b1, CELL, 0);
        add_req(OP_STEP, 1'b1, POS_MAX, POS_MAX);
        add_req(OP_QUERY, 1'b0, CELL, CELL);
        add_req(OP_QUERY, 1'b1, 0, 0);
        add_req(OP_QUERY, 1'b0, (COLS - 2) * CELL, (ROWS - 2) * CELL);
        add_req(OP_SET, 1'b0, CELL, CELL - 1);
        add_req(OP_QUERY, 1'b1, CELL + 5, 3);
        add_req(OP_STEP, 1'b0, 0, 0);
        add_req(OP_QUERY, 1'b1, COLS * CELL - 1, ROWS * CELL - 1);
        add_req(OP_CLEAR, 1'b1, POS_MAX, 0);
        add_req(OP_QUERY, 1'b0, COLS * CELL - 1, ROWS * CELL - 1);
        add_req(OP_STEP, 1'b1, 0, POS_MAX);
        add_req(OP_QUERY, 1'b1, 0, 0);

        // Four phases of random requests: no idling, a sluggish sender, a
        // sluggish receiver, and light idling on both sides. The first phase
        // also holds the receiver off long enough that the block backs up.
        // Between phases the sender waits until every owed result is back.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
            target = queued_count + RAND_REQS / 4;
            while (queued_count < target)
            begin
                kind = $urandom_range(99);
                if (kind < 65)
                begin
                    // A small pattern in a window, evolved a few generations
                    // and probed in and around the window after each one.
                    if ($urandom_range(1))
                        add_req(OP_CLEAR, $urandom_range(1), $urandom_range(POS_MAX),
                                $urandom_range(POS_MAX));
                    base_r = window_base(ROWS);
                    base_c = window_base(COLS);
                    repeat ($urandom_range(4, 16))
                        add_req(OP_SET, $urandom_range(9) != 0,
                                cell_px(base_c + $urandom_range(5)),
                                cell_px(base_r + $urandom_range(5)));
                    repeat ($urandom_range(1, 4))
                    begin
                        add_req(OP_STEP, $urandom_range(1), $urandom_range(POS_MAX),
                                $urandom_range(POS_MAX));
                        repeat ($urandom_range(2, 6))
                            add_req(OP_QUERY, $urandom_range(1),
                                    cell_px(base_c + $urandom_range(5)),
                                    cell_px(base_r + $urandom_range(5)));
                        if ($urandom_range(3) == 0)
                            add_req(OP_QUERY, $urandom_range(1),
                                    cell_px($urandom_range(COLS - 1)),
                                    cell_px($urandom_range(ROWS - 1)));
                    end
                end
                else if (kind < 85)
                begin
                    // Any operation with every field drawn over its full range.
                    add_req(op_t'($urandom_range(3)), $urandom_range(1),
                            $urandom_range(POS_MAX), $urandom_range(POS_MAX));
                end
                else
                begin
                    // Set or query close to the far grid border on either axis,
                    // on both sides of it.
                    add_req($urandom_range(1) ? OP_SET : OP_QUERY, $urandom_range(1),
                            $urandom_range(1) ? $urandom_range(COLS * CELL - 2, COLS * CELL + 1)
                                              : cell_px($urandom_range(COLS - 1)),
                            $urandom_range(1) ? $urandom_range(ROWS * CELL - 2, ROWS * CELL + 1)
                                              : cell_px($urandom_range(ROWS - 1)));
                end
            end
            if (phase == 0)
                hold_requests++;
            while (pending_reqs.size() != 0 || owed_rsps.size() != 0)
                @(posedge clk);
        end

        // Let the drain period pass so that a stray extra result would be seen.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d sets, %0d queries (%0d live), %0d clears, %0d steps.",
                 rsp_checked, n_set, n_query, n_live_seen, n_clear, n_step);
        $display("%0d requests addressed a cell off the grid; four handshake phases ran.",
                 n_off_grid);
        if (errors == 0 && owed_rsps.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
